/* rtl/core/mcsff_pkg.sv */
`default_nettype none
package mcsff_pkg;
	localparam int MaxRows = 64;
	localparam int MaxCols = 64;
	localparam int Cells = MaxRows * MaxCols;
	localparam int AddrW = $clog2(Cells);
	localparam int RcW = $clog2(MaxRows);
	localparam int DepthW = 10;
	localparam int SumW = 22;
	localparam int CfgW = 7;
	localparam int SpW = AddrW + 1;
	localparam logic [SumW-1:0] SumMax = {SumW{1'b1}};

	typedef enum logic [0:0] {
		REG_ROWS = 1'b0,
		REG_COLS = 1'b1
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_CLEAR,
		ST_SCAN_RD,
		ST_SCAN_CHK,
		ST_POP_RD,
		ST_POP_CHK,
		ST_NB_RD,
		ST_NB_CHK,
		ST_REGION_END,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic load_wr;
		logic clr_step;
		logic scan_rd;
		logic scan_chk;
		logic pop_rd;
		logic pop_chk;
		logic nb_rd;
		logic nb_chk;
		logic region_end;
		logic out_valid;
		logic init;
	} ctrl_t;

	typedef struct packed {
		logic load_last;
		logic clr_done;
		logic scan_done;
		logic stack_empty;
		logic nb_last;
	} stat_t;
endpackage
`default_nettype wire

/* rtl/core/max_component_sum_flood_fill.sv */
// flow: one cell per cycle while loading; after the last cell a clearing pass sweeps all 4096
// visited entries, then each cell is scanned, each region cell is popped and its four neighbours
// checked, each region closes with a best-sum update, then the result is held until taken
// throughput: one grid at a time; input is held off from the last cell until the result leaves
// reset: arst_n clears control, sizes return to 64 by 64, the visited map is swept per grid
`default_nettype none
module max_component_sum_flood_fill (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,   // cell_depth [9:0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [23:0]      m_tdata,   // max_lake_volume [21:0]
	input  wire logic        cfg_we,
	input  wire logic [0:0]  cfg_idx,
	input  wire logic [6:0]  cfg_data
);
	import mcsff_pkg::*;

	ctrl_t ctrl;
	stat_t stat;
	logic [SumW-1:0] best;
	logic in_fire;

	assign in_fire = s_tvalid && s_tready;

	mcsff_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire), .out_fire(m_tvalid && m_tready),
		.stat(stat), .ctrl(ctrl), .in_ready(s_tready));

	mcsff_dp u_dp (
		.clk(clk), .arst_n(arst_n), .ctrl(ctrl), .cell_depth(s_tdata[DepthW-1:0]),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx[0]), .cfg_data(cfg_data),
		.stat(stat), .best(best));

	assign m_tvalid = ctrl.out_valid;
	assign m_tdata = {2'b00, best};
endmodule
`default_nettype wire

/* rtl/core/mcsff_ram.sv */
`default_nettype none
module mcsff_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(Depth)-1:0] waddr,
	input  wire logic [Width-1:0]         wdata,
	input  wire logic [$clog2(Depth)-1:0] raddr,
	output logic      [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

/* rtl/core/mcsff_ctrl.sv */
`default_nettype none
module mcsff_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_fire,
	input  wire logic              out_fire,
	input  wire mcsff_pkg::stat_t  stat,
	output mcsff_pkg::ctrl_t       ctrl,
	output logic                   in_ready
);
	import mcsff_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_LOAD: if (in_fire && stat.load_last) state_d = ST_CLEAR;
			ST_CLEAR: if (stat.clr_done) state_d = ST_SCAN_RD;
			ST_SCAN_RD: state_d = ST_SCAN_CHK;
			ST_SCAN_CHK: begin
				if (stat.scan_done) state_d = ST_OUT;
				else if (!stat.stack_empty) state_d = ST_POP_RD;
				else state_d = ST_SCAN_RD;
			end
			ST_POP_RD: state_d = ST_POP_CHK;
			ST_POP_CHK: state_d = ST_NB_RD;
			ST_NB_RD: state_d = ST_NB_CHK;
			ST_NB_CHK: begin
				if (!stat.nb_last) state_d = ST_NB_RD;
				else if (stat.stack_empty) state_d = ST_REGION_END;
				else state_d = ST_POP_RD;
			end
			ST_REGION_END: state_d = ST_SCAN_RD;
			ST_OUT: if (out_fire) state_d = ST_LOAD;
			default: state_d = ST_LOAD;
		endcase
	end

	always_comb begin
		ctrl = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_LOAD: begin
				in_ready = 1'b1;
				ctrl.load_wr = in_fire;
				ctrl.init = in_fire && stat.load_last;
			end
			ST_CLEAR: ctrl.clr_step = 1'b1;
			ST_SCAN_RD: ctrl.scan_rd = 1'b1;
			ST_SCAN_CHK: ctrl.scan_chk = 1'b1;
			ST_POP_RD: ctrl.pop_rd = 1'b1;
			ST_POP_CHK: ctrl.pop_chk = 1'b1;
			ST_NB_RD: ctrl.nb_rd = 1'b1;
			ST_NB_CHK: ctrl.nb_chk = 1'b1;
			ST_REGION_END: ctrl.region_end = 1'b1;
			ST_OUT: ctrl.out_valid = 1'b1;
			default: ctrl = '0;
		endcase
	end

`ifndef SYNTHESIS
	a_ready_load: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !ctrl.out_valid) else $error("ready while holding result");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.out_valid && !out_fire) |=> ctrl.out_valid) else $error("result dropped");
	a_nb_after_rd: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.nb_rd |=> ctrl.nb_chk) else $error("neighbour check missing");
`endif
endmodule
`default_nettype wire

/* rtl/core/mcsff_dp.sv */
`default_nettype none
module mcsff_dp (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire mcsff_pkg::ctrl_t              ctrl,
	input  wire logic [mcsff_pkg::DepthW-1:0]  cell_depth,
	input  wire logic                          cfg_we,
	input  wire logic                          cfg_idx,
	input  wire logic [mcsff_pkg::CfgW-1:0]    cfg_data,
	output mcsff_pkg::stat_t                   stat,
	output logic [mcsff_pkg::SumW-1:0]         best
);
	import mcsff_pkg::*;

	logic [CfgW-1:0] rows_cfg_q, cols_cfg_q;
	logic [RcW:0] rows_q, cols_q;
	logic [RcW:0] rows_e, cols_e;
	logic [AddrW:0] load_cnt_q, total_q;
	logic [AddrW:0] start_q;
	logic [RcW:0] start_r_q, start_c_q;
	logic [SpW-1:0] sp_q;
	logic [AddrW-1:0] cur_q, nb_q;
	logic [RcW:0] cur_r_q, cur_c_q, nb_r_q, nb_c_q;
	logic [1:0] dir_q;
	logic nb_ok_q;
	logic [SumW-1:0] sum_q, best_q;
	logic [AddrW:0] clr_q;

	logic d_we, v_we, v_wd, v_rd, s_we;
	logic [AddrW-1:0] d_waddr, d_raddr, v_addr, s_waddr, s_raddr;
	logic [DepthW-1:0] d_rd;
	logic [2*RcW-1:0] s_wd, s_rd;
	logic [RcW-1:0] pop_r, pop_c;
	logic [AddrW-1:0] pop_idx;
	logic [SumW:0] sum_ext;
	logic [AddrW-1:0] nb_addr;
	logic [RcW:0] nb_r, nb_c;
	logic nb_in;
	logic scan_adv;

	always_comb begin
		rows_e = (rows_cfg_q == '0) ? (RcW+1)'(1)
			: (rows_cfg_q > CfgW'(MaxRows)) ? (RcW+1)'(MaxRows) : (RcW+1)'(rows_cfg_q);
		cols_e = (cols_cfg_q == '0) ? (RcW+1)'(1)
			: (cols_cfg_q > CfgW'(MaxCols)) ? (RcW+1)'(MaxCols) : (RcW+1)'(cols_cfg_q);
	end

	// size registers and raster position of the load
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_cfg_q <= CfgW'(MaxRows);
			cols_cfg_q <= CfgW'(MaxCols);
			load_cnt_q <= '0;
		end else if (cfg_we) begin
			if (cfg_idx == REG_ROWS) rows_cfg_q <= cfg_data;
			else cols_cfg_q <= cfg_data;
			load_cnt_q <= '0;
		end else if (ctrl.load_wr) begin
			load_cnt_q <= stat.load_last ? '0 : load_cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.init) begin
			rows_q <= rows_e;
			cols_q <= cols_e;
		end
	end

	assign stat.load_last = (load_cnt_q + 1'b1) == ((AddrW+1)'(rows_e) * (AddrW+1)'(cols_e));

	mcsff_ram #(.Width(DepthW), .Depth(Cells)) u_depth (
		.clk(clk), .we(d_we), .waddr(d_waddr), .wdata(cell_depth),
		.raddr(d_raddr), .rdata(d_rd));
	mcsff_ram #(.Width(1), .Depth(Cells)) u_visit (
		.clk(clk), .we(v_we), .waddr(v_addr), .wdata(v_wd),
		.raddr(v_addr), .rdata(v_rd));
	mcsff_ram #(.Width(2*RcW), .Depth(Cells)) u_stack (
		.clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wd),
		.raddr(s_raddr), .rdata(s_rd));

	assign d_we = ctrl.load_wr;
	assign d_waddr = load_cnt_q[AddrW-1:0];

	// stack entries hold row and column of a cell
	assign pop_r = s_rd[2*RcW-1:RcW];
	assign pop_c = s_rd[RcW-1:0];
	assign pop_idx = AddrW'(pop_r) * AddrW'(cols_q) + AddrW'(pop_c);

	// neighbour address for direction dir_q: down, right, up, left
	always_comb begin
		nb_addr = cur_q;
		nb_r = cur_r_q;
		nb_c = cur_c_q;
		nb_in = 1'b0;
		case (dir_q)
			2'd0: begin
				nb_addr = cur_q + AddrW'(cols_q);
				nb_r = cur_r_q + 1'b1;
				nb_in = (cur_r_q + 1'b1) < rows_q;
			end
			2'd1: begin
				nb_addr = cur_q + 1'b1;
				nb_c = cur_c_q + 1'b1;
				nb_in = (cur_c_q + 1'b1) < cols_q;
			end
			2'd2: begin
				nb_addr = cur_q - AddrW'(cols_q);
				nb_r = cur_r_q - 1'b1;
				nb_in = cur_r_q != '0;
			end
			2'd3: begin
				nb_addr = cur_q - 1'b1;
				nb_c = cur_c_q - 1'b1;
				nb_in = cur_c_q != '0;
			end
			default: nb_in = 1'b0;
		endcase
	end

	always_comb begin
		d_raddr = start_q[AddrW-1:0];
		v_addr = start_q[AddrW-1:0];
		v_we = 1'b0;
		v_wd = 1'b0;
		if (ctrl.clr_step) begin
			v_addr = clr_q[AddrW-1:0];
			v_we = 1'b1;
		end else if (ctrl.nb_rd) begin
			d_raddr = nb_addr;
			v_addr = nb_addr;
		end else if (ctrl.nb_chk) begin
			v_addr = nb_q;
			v_we = nb_ok_q && !v_rd && d_rd != '0;
			v_wd = 1'b1;
		end else if (ctrl.pop_chk) begin
			d_raddr = pop_idx;
		end else if (ctrl.scan_chk) begin
			v_we = !v_rd && d_rd != '0 && !stat.scan_done;
			v_wd = 1'b1;
		end
	end

	assign s_we = (ctrl.nb_chk && v_we) || (ctrl.scan_chk && v_we);
	assign s_waddr = sp_q[AddrW-1:0];
	assign s_raddr = sp_q[AddrW-1:0] - 1'b1;
	assign s_wd = ctrl.scan_chk ? {start_r_q[RcW-1:0], start_c_q[RcW-1:0]}
		: {nb_r_q[RcW-1:0], nb_c_q[RcW-1:0]};

	assign stat.clr_done = clr_q == (AddrW+1)'(Cells - 1);
	assign stat.scan_done = start_q == total_q;
	assign stat.stack_empty = ctrl.scan_chk ? !v_we : ((sp_q == '0) && !s_we);
	assign stat.nb_last = dir_q == 2'd3;

	assign sum_ext = {1'b0, sum_q} + (SumW+1)'(d_rd);
	assign scan_adv = (ctrl.scan_chk && !stat.scan_done && stat.stack_empty) || ctrl.region_end;

	always_ff @(posedge clk) begin
		if (ctrl.init) begin
			total_q <= (AddrW+1)'(rows_e) * (AddrW+1)'(cols_e);
			clr_q <= '0;
			start_q <= '0;
			start_r_q <= '0;
			start_c_q <= '0;
			sp_q <= '0;
		end
		if (ctrl.clr_step) clr_q <= clr_q + 1'b1;
		if (ctrl.scan_chk) sum_q <= '0;
		if (s_we) sp_q <= sp_q + 1'b1;
		if (ctrl.pop_rd) sp_q <= sp_q - 1'b1;
		if (ctrl.pop_chk) begin
			cur_q <= pop_idx;
			cur_r_q <= {1'b0, pop_r};
			cur_c_q <= {1'b0, pop_c};
			dir_q <= 2'd0;
		end
		if (ctrl.nb_rd) begin
			nb_q <= nb_addr;
			nb_r_q <= nb_r;
			nb_c_q <= nb_c;
			nb_ok_q <= nb_in;
			// depth of the popped cell arrives with the first neighbour read
			if (dir_q == 2'd0) sum_q <= sum_ext[SumW] ? SumMax : sum_ext[SumW-1:0];
		end
		if (ctrl.nb_chk) dir_q <= dir_q + 1'b1;
		if (scan_adv) begin
			start_q <= start_q + 1'b1;
			if ((start_c_q + 1'b1) == cols_q) begin
				start_c_q <= '0;
				start_r_q <= start_r_q + 1'b1;
			end else begin
				start_c_q <= start_c_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_q <= '0;
		end else if (ctrl.init) begin
			best_q <= '0;
		end else if (ctrl.region_end && sum_q > best_q) begin
			best_q <= sum_q;
		end
	end

	assign best = best_q;

`ifndef SYNTHESIS
	a_sp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.pop_rd |-> sp_q != '0) else $error("pop from empty stack");
	a_push_cap: assert property (@(posedge clk) disable iff (!arst_n)
		s_we |-> sp_q < SpW'(Cells)) else $error("stack overflow");
	a_clr_count: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.init |=> clr_q == '0) else $error("clear pass not reset");
`endif
endmodule
`default_nettype wire
